[src/pcs_pkg.sv]
// shared types and constants of the peer clock sync engine
package pcs_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SYNC_START = 3'd1,
    OP_LEADER     = 3'd2,
    OP_DELAY_REQ  = 3'd3,
    OP_DELAY_RESP = 3'd4,
    OP_GET_TIME   = 3'd5,
    OP_BAD        = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_BCAST      = 3'd1,
    ACT_DELAY_REQ  = 3'd2,
    ACT_DELAY_RESP = 3'd3,
    ACT_TIME_REPLY = 3'd4,
    ACT_ERROR      = 3'd5
  } act_e;

  localparam logic [1:0] REG_SYNC_LOSS    = 2'd0;
  localparam logic [1:0] REG_EXCHANGE     = 2'd1;
  localparam logic [1:0] REG_START_PERIOD = 2'd2;
  localparam logic [1:0] REG_LEADER_DELAY = 2'd3;

  localparam logic [19:0] SYNC_LOSS_RST    = 20'd20000;
  localparam logic [19:0] EXCHANGE_RST     = 20'd10000;
  localparam logic [19:0] START_PERIOD_RST = 20'd5000;
  localparam logic [19:0] LEADER_DELAY_RST = 20'd2000;

  localparam logic [7:0] LEVEL_NONE     = 8'd255;
  localparam logic [7:0] LEVEL_NO_BCAST = 8'd254;

  typedef struct packed {
    logic [19:0] sync_loss;
    logic [19:0] exchange;
    logic [19:0] start_period;
    logic [19:0] leader_delay;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [47:0] sender;
    logic        conn;
    logic        len_ok;
    logic [7:0]  level;
    logic [63:0] stamp;
    logic [63:0] now;
    logic        peers;
  } item_t;

  typedef struct packed {
    act_e        action;
    logic [7:0]  out_level;
    logic [63:0] out_stamp;
    logic [7:0]  node_level;
  } res_t;

endpackage

[src/peer_clock_sync_level_protocol_unit.sv]
// top level of the peer clock sync engine: register port, front end and engine
// Usage: events are pushed as words on the input queue (push/full); every word
// yields exactly one result word on the output queue (empty/pop), in order.
// A word is registered in the front queue, and the engine writes its result
// into the result queue, from which it reaches the result ports.
// Throughput is one word per cycle while the result queue has room: the engine
// updates the whole sync state at once, and that state loop sets the rate.
// Both queues are two words deep; when the receiver stops popping, the result
// queue fills, the engine holds, the front queue fills and full rises.
// Timeout and period registers sit on an APB-style port at byte addresses
// 0, 4, 8 and 12 (20 bits each); write them only while the block is idle.
// Reset empties both queues, puts the node at level 255, unsynced, not
// leader, with zeroed offset, stamps and timers and default timeouts.
module peer_clock_sync_level_protocol_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op_i,
  input  logic [47:0] sender_i,
  input  logic        sender_connected_i,
  input  logic        length_ok_i,
  input  logic [7:0]  level_in_i,
  input  logic [63:0] stamp_in_i,
  input  logic [63:0] now_ms_i,
  input  logic        have_peers_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action_o,
  output logic [7:0]  out_level_o,
  output logic [63:0] out_stamp_o,
  output logic [7:0]  node_level_o
);
  import pcs_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  logic  item_valid, item_take, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sync_loss: SYNC_LOSS_RST, exchange: EXCHANGE_RST,
                 start_period: START_PERIOD_RST, leader_delay: LEADER_DELAY_RST};
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SYNC_LOSS:    cfg_q.sync_loss    <= pwdata[19:0];
        REG_EXCHANGE:     cfg_q.exchange     <= pwdata[19:0];
        REG_START_PERIOD: cfg_q.start_period <= pwdata[19:0];
        REG_LEADER_DELAY: cfg_q.leader_delay <= pwdata[19:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SYNC_LOSS:    prdata = {12'd0, cfg_q.sync_loss};
      REG_EXCHANGE:     prdata = {12'd0, cfg_q.exchange};
      REG_START_PERIOD: prdata = {12'd0, cfg_q.start_period};
      REG_LEADER_DELAY: prdata = {12'd0, cfg_q.leader_delay};
      default:          prdata = 32'd0;
    endcase
  end

  pcs_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .op_i,
    .sender_i,
    .sender_connected_i,
    .length_ok_i,
    .level_in_i,
    .stamp_in_i,
    .now_ms_i,
    .have_peers_i,
    .valid_o (item_valid),
    .item_o  (item),
    .take_i  (item_take)
  );

  pcs_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg_q),
    .valid_i (item_valid),
    .item_i  (item),
    .take_o  (item_take),
    .empty,
    .pop,
    .res_o   (res)
  );

  assign action_o     = res.action;
  assign out_level_o  = res.out_level;
  assign out_stamp_o  = res.out_stamp;
  assign node_level_o = res.node_level;

endmodule

[src/pcs_front.sv]
// front end: takes words, classifies the op and queues them for the engine
module pcs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           op_i,
  input  logic [47:0]          sender_i,
  input  logic                 sender_connected_i,
  input  logic                 length_ok_i,
  input  logic [7:0]           level_in_i,
  input  logic [63:0]          stamp_in_i,
  input  logic [63:0]          now_ms_i,
  input  logic                 have_peers_i,
  output logic                 valid_o,
  output pcs_pkg::item_t       item_o,
  input  logic                 take_i
);
  import pcs_pkg::*;

  item_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;
  item_t       item_in;
  op_e         op_cls;
  logic        wr_en, rd_en;

  always_comb begin
    unique case (op_i)
      3'd0:    op_cls = OP_TICK;
      3'd1:    op_cls = OP_SYNC_START;
      3'd2:    op_cls = OP_LEADER;
      3'd3:    op_cls = OP_DELAY_REQ;
      3'd4:    op_cls = OP_DELAY_RESP;
      3'd5:    op_cls = OP_GET_TIME;
      default: op_cls = OP_BAD;
    endcase
  end

  assign item_in = '{op: op_cls, sender: sender_i, conn: sender_connected_i,
                     len_ok: length_ok_i, level: level_in_i, stamp: stamp_in_i,
                     now: now_ms_i, peers: have_peers_i};

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];
  assign wr_en   = push && !full;
  assign rd_en   = take_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) cnt_d = cnt_q + 2'd1;
    else if (!wr_en && rd_en) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= item_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_en) wptr_q <= ~wptr_q;
      if (rd_en) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

[src/pcs_back.sv]
// back end: sync state machine update and result queue
module pcs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcs_pkg::cfg_t        cfg_i,
  input  logic                 valid_i,
  input  pcs_pkg::item_t       item_i,
  output logic                 take_o,
  output logic                 empty,
  input  logic                 pop,
  output pcs_pkg::res_t        res_o
);
  import pcs_pkg::*;

  typedef struct packed {
    logic [63:0] offset;
    logic [63:0] t1;
    logic [63:0] d1;
    logic [63:0] t3;
    logic [7:0]  exp_level;
    logic        synced;
    logic [47:0] peer_id;
    logic [7:0]  peer_level;
    logic [7:0]  level;
  } sync_t;

  localparam sync_t SYNC_CLEAR = '{offset: 64'd0, t1: 64'd0, d1: 64'd0, t3: 64'd0,
                                   exp_level: 8'd0, synced: 1'b0, peer_id: 48'd0,
                                   peer_level: LEVEL_NONE, level: LEVEL_NONE};

  sync_t       s_q, s_d;
  logic [47:0] cand_id_q, cand_id_d;
  logic [7:0]  cand_level_q, cand_level_d;
  logic        inx_q, inx_d;
  logic [1:0]  lf_q, lf_d;
  logic [63:0] mark0_q, mark0_d, mark1_q, mark1_d, mark2_q, mark2_d;
  res_t        res;

  res_t        rq_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        fire, rd_en;

  assign fire   = valid_i && (cnt_q != 2'd2);
  assign take_o = fire;
  assign rd_en  = pop && !empty;
  assign empty  = (cnt_q == 2'd0);
  assign res_o  = rq_q[rptr_q];

  always_comb begin
    logic        leading, start_pend, from_peer;
    logic [63:0] now, d2;
    logic [64:0] sum, rnd;
    act_e        act;
    leading      = lf_q[0];
    start_pend   = lf_q[1];
    now          = item_i.now;
    s_d          = s_q;
    cand_id_d    = cand_id_q;
    cand_level_d = cand_level_q;
    inx_d        = inx_q;
    mark0_d      = mark0_q;
    mark1_d      = mark1_q;
    mark2_d      = mark2_q;
    act          = ACT_NONE;
    from_peer    = (item_i.sender == s_q.peer_id);
    // offset: halve the 65-bit sum toward zero
    d2  = s_q.t3 - item_i.stamp;
    sum = {s_q.d1[63], s_q.d1} + {d2[63], d2};
    rnd = sum + {64'd0, sum[64]};

    unique case (item_i.op)
      OP_TICK: begin
        if ((now - mark1_q) >= {44'd0, cfg_i.sync_loss} && s_d.synced) s_d = SYNC_CLEAR;
        if ((now - s_d.t3) >= {44'd0, cfg_i.exchange} && inx_d) begin
          inx_d        = 1'b0;
          cand_id_d    = 48'd0;
          cand_level_d = LEVEL_NONE;
        end
        if (((start_pend && (now - mark2_d) >= {44'd0, cfg_i.leader_delay}) ||
             (!start_pend && (now - mark0_d) >= {44'd0, cfg_i.start_period})) &&
            s_d.level < LEVEL_NO_BCAST && item_i.peers) begin
          act        = ACT_BCAST;
          start_pend = 1'b0;
          mark0_d    = now;
        end
      end
      OP_SYNC_START: begin
        if (!((!inx_q || from_peer) && !leading)) act = ACT_ERROR;
        else if (!item_i.conn) act = ACT_ERROR;
        else if (inx_q && from_peer && s_q.synced) mark1_d = now;
        else if (!inx_q) begin
          if (!item_i.len_ok) act = ACT_ERROR;
          else begin
            if (from_peer && s_q.synced) begin
              if (item_i.level < s_q.peer_level) begin
                cand_id_d      = s_q.peer_id;
                cand_level_d   = s_q.peer_level;
                s_d.peer_level = item_i.level;
                inx_d          = 1'b1;
                mark1_d        = now;
              end else if (item_i.level >= s_q.level) begin
                s_d   = SYNC_CLEAR;
                inx_d = 1'b0;
              end else begin
                mark1_d = now;
              end
            end else if (({1'b0, item_i.level} + 9'd2) <= {1'b0, s_q.level}) begin
              cand_id_d    = item_i.sender;
              cand_level_d = item_i.level;
              inx_d        = 1'b1;
            end else begin
              act = ACT_ERROR;
            end
            if (inx_d) begin
              s_d.t1        = item_i.stamp;
              s_d.d1        = now - item_i.stamp;
              s_d.exp_level = item_i.level;
              s_d.t3        = now;
              act           = ACT_DELAY_REQ;
            end
          end
        end
      end
      OP_LEADER: begin
        if (!item_i.len_ok) act = ACT_ERROR;
        else if (item_i.level == 8'd0 && s_q.level != 8'd0) begin
          leading    = 1'b1;
          start_pend = 1'b1;
          mark2_d    = now;
          s_d        = SYNC_CLEAR;
          s_d.level  = 8'd0;
          inx_d      = 1'b0;
        end else if (item_i.level == LEVEL_NONE && s_q.level == 8'd0) begin
          s_d        = SYNC_CLEAR;
          leading    = 1'b0;
          start_pend = 1'b0;
        end else if (s_q.level != 8'd0) act = ACT_ERROR;
      end
      OP_DELAY_REQ: act = (item_i.conn && item_i.len_ok) ? ACT_DELAY_RESP : ACT_ERROR;
      OP_DELAY_RESP: begin
        if (!inx_q || !item_i.conn || item_i.sender != cand_id_q || !item_i.len_ok)
          act = ACT_ERROR;
        else begin
          if (s_q.t3 > now || (now - s_q.t3) >= {44'd0, cfg_i.exchange} ||
              item_i.stamp < s_q.t1) act = ACT_ERROR;
          else if (s_q.exp_level == item_i.level) begin
            s_d.offset     = rnd[64:1];
            s_d.level      = item_i.level + 8'd1;
            s_d.peer_id    = cand_id_q;
            s_d.peer_level = cand_level_q;
            s_d.synced     = 1'b1;
            mark1_d        = now;
          end else act = ACT_ERROR;
          inx_d = 1'b0;
        end
      end
      OP_GET_TIME: act = item_i.len_ok ? ACT_TIME_REPLY : ACT_ERROR;
      default:     act = ACT_ERROR;
    endcase

    lf_d = {start_pend, leading};
    res.action     = act;
    res.node_level = s_d.level;
    if (act == ACT_BCAST || act == ACT_DELAY_RESP || act == ACT_TIME_REPLY) begin
      res.out_level = s_d.level;
      res.out_stamp = now - s_d.offset;
    end else begin
      res.out_level = 8'd0;
      res.out_stamp = 64'd0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (fire && !rd_en) cnt_d = cnt_q + 2'd1;
    else if (!fire && rd_en) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (fire) rq_q[wptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q          <= SYNC_CLEAR;
      cand_id_q    <= 48'd0;
      cand_level_q <= LEVEL_NONE;
      inx_q        <= 1'b0;
      lf_q         <= 2'd0;
      mark0_q      <= 64'd0;
      mark1_q      <= 64'd0;
      mark2_q      <= 64'd0;
      wptr_q       <= 1'b0;
      rptr_q       <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      if (fire) begin
        s_q          <= s_d;
        cand_id_q    <= cand_id_d;
        cand_level_q <= cand_level_d;
        inx_q        <= inx_d;
        lf_q         <= lf_d;
        mark0_q      <= mark0_d;
        mark1_q      <= mark1_d;
        mark2_q      <= mark2_d;
        wptr_q       <= ~wptr_q;
      end
      if (rd_en) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule
